### hw/rtl/obb_pkg.sv
package obb_pkg;

    // event codes on the result channel
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTER = 2'd1;
    localparam logic [1:0] EV_STAY  = 2'd2;
    localparam logic [1:0] EV_EXIT  = 2'd3;

    localparam logic [0:0] OP_BOX    = 1'b0;
    localparam logic [0:0] OP_CIRCLE = 1'b1;

    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    localparam logic [63:0] PI_HALF_Q30  = 64'd1686629713;
    localparam logic [63:0] ONE_Q30      = 64'd1 << 30;

    // multiplier lane operand and product widths
    localparam int LANE_W = 34;
    localparam int PROD_W = 2 * LANE_W;

    // classified pair handed from front to back
    typedef struct packed {
        logic               op;
        logic [5:0]         id;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [25:0] ca;
        logic signed [25:0] sa;
        logic signed [25:0] cb;
        logic signed [25:0] sb;
        logic [30:0]        s0;
        logic [30:0]        s1;
        logic [30:0]        s2;
        logic [30:0]        s3;
    } job_t;

    // one sine table entry in Q24 from a Q32 phase, Taylor series in Q30
    function automatic logic signed [25:0] sine_entry(input logic [63:0] u);
        logic [63:0]        q;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic signed [63:0] m;
        logic               odd;
        q   = (u >> 30) & 64'd3;
        x   = ((u & (ONE_Q30 - 64'd1)) * PI_HALF_Q30) >> 30;
        x2  = (x * x) >> 30;
        odd = (q[0] == 1'b0);
        t   = odd ? x : ONE_Q30;
        s   = $signed(t);
        for (int i = 0; i < 7; i++) begin
            t = (t * x2) >> 30;
            if (odd) begin
                case (i)
                    0: t = t / 6;
                    1: t = t / 20;
                    2: t = t / 42;
                    3: t = t / 72;
                    4: t = t / 110;
                    5: t = t / 156;
                    default: t = t / 210;
                endcase
            end else begin
                case (i)
                    0: t = t / 2;
                    1: t = t / 12;
                    2: t = t / 30;
                    3: t = t / 56;
                    4: t = t / 90;
                    5: t = t / 132;
                    default: t = t / 182;
                endcase
            end
            if (i % 2 == 1) s = s + $signed(t);
            else            s = s - $signed(t);
        end
        if (s < 0) s = 0;
        if (s > $signed(ONE_Q30)) s = $signed(ONE_Q30);
        m = (s + 64'sd32) >>> 6;
        if (q >= 64'd2) m = -m;
        return m[25:0];
    endfunction

endpackage

### hw/rtl/obb_circle_overlap_contact_tracker.sv
// The back sequencer steps four shared multiplier lanes over the product list of
// one pair at a time and registers the result word; it holds the last step while
// the previous result word has not been taken (m_ready low).
// A two-word queue lets the input side accept while the back end is busy.
// Reset (aresetn low, synchronous) empties the queue, drops any result and
// clears the whole contact table at once.
module obb_circle_overlap_contact_tracker
    import obb_pkg::*;
#(
    parameter int MAX_OBJECTS      = 64,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [5:0]         s_other_id,
    input  logic signed [31:0] s_own_x,
    input  logic signed [31:0] s_own_y,
    input  logic [15:0]        s_own_angle,
    input  logic [30:0]        s_own_size_a,
    input  logic [30:0]        s_own_size_b,
    input  logic signed [31:0] s_other_x,
    input  logic signed [31:0] s_other_y,
    input  logic [15:0]        s_other_angle,
    input  logic [30:0]        s_other_size_a,
    input  logic [30:0]        s_other_size_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_event_res,
    output logic [5:0]         m_event_id,
    output logic               m_overlapping
);

    job_t front_job;
    job_t back_job;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign s_ready = !q_full;

    // classify and fetch angles
    obb_front #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_front (
        .operation    (s_operation),
        .other_id     (s_other_id),
        .own_x        (s_own_x),
        .own_y        (s_own_y),
        .own_angle    (s_own_angle),
        .own_size_a   (s_own_size_a),
        .own_size_b   (s_own_size_b),
        .other_x      (s_other_x),
        .other_y      (s_other_y),
        .other_angle  (s_other_angle),
        .other_size_a (s_other_size_a),
        .other_size_b (s_other_size_b),
        .job          (front_job)
    );

    obb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_data (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (back_job)
    );

    obb_back #(.MAX_OBJECTS(MAX_OBJECTS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_empty     (q_empty),
        .job           (back_job),
        .job_pop       (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_event_id    (m_event_id),
        .m_overlapping (m_overlapping)
    );

    // enter and stay only come with an overlap
    a_enter_stay_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_ENTER || m_event_res == EV_STAY) |-> m_overlapping)
        else $error("enter or stay without overlap");

    // exit only comes without an overlap
    a_exit_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_EXIT) |-> !m_overlapping)
        else $error("exit with overlap");

    // ids past the table give no event
    a_range_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ({26'd0, m_event_id} >= 32'(MAX_OBJECTS)) |-> (m_event_res == EV_NONE))
        else $error("event for id beyond table");

endmodule

### hw/rtl/obb_front.sv
module obb_front
    import obb_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic               operation,
    input  logic [5:0]         other_id,
    input  logic signed [31:0] own_x,
    input  logic signed [31:0] own_y,
    input  logic [15:0]        own_angle,
    input  logic [30:0]        own_size_a,
    input  logic [30:0]        own_size_b,
    input  logic signed [31:0] other_x,
    input  logic signed [31:0] other_y,
    input  logic [15:0]        other_angle,
    input  logic [30:0]        other_size_a,
    input  logic [30:0]        other_size_b,
    output job_t               job
);

    localparam int SIN_AW = $clog2(SINE_TABLE_DEPTH);
    localparam int IDXP_W = 16 + SIN_AW + 1;

    // constant sine table, one full turn
    logic signed [25:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] PHASE = (64'(k) << 32) / SINE_TABLE_DEPTH;
        assign sine_rom[k] = sine_entry(PHASE);
    end

    logic [15:0]       own_cang;
    logic [15:0]       oth_cang;
    logic [IDXP_W-1:0] idx_sa;
    logic [IDXP_W-1:0] idx_ca;
    logic [IDXP_W-1:0] idx_sb;
    logic [IDXP_W-1:0] idx_cb;

    // angle to table index; cosine is a quarter turn ahead
    assign own_cang = own_angle + QUARTER_TURN;
    assign oth_cang = other_angle + QUARTER_TURN;
    assign idx_sa = IDXP_W'(own_angle) * IDXP_W'(SINE_TABLE_DEPTH);
    assign idx_ca = IDXP_W'(own_cang) * IDXP_W'(SINE_TABLE_DEPTH);
    assign idx_sb = IDXP_W'(other_angle) * IDXP_W'(SINE_TABLE_DEPTH);
    assign idx_cb = IDXP_W'(oth_cang) * IDXP_W'(SINE_TABLE_DEPTH);

    // classify the pair and gather its operands
    always_comb begin
        job.op = operation;
        job.id = other_id;
        job.dx = 33'(own_x) - 33'(other_x);
        job.dy = 33'(own_y) - 33'(other_y);
        job.sa = sine_rom[idx_sa[SIN_AW+15:16]];
        job.ca = sine_rom[idx_ca[SIN_AW+15:16]];
        job.sb = sine_rom[idx_sb[SIN_AW+15:16]];
        job.cb = sine_rom[idx_cb[SIN_AW+15:16]];
        job.s0 = own_size_a;
        job.s1 = own_size_b;
        job.s2 = other_size_a;
        job.s3 = other_size_b;
    end

endmodule

### hw/rtl/obb_fifo.sv
module obb_fifo
    import obb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t pop_data
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // two-word queue between front and back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### hw/rtl/obb_back.sv
module obb_back
    import obb_pkg::*;
#(
    parameter int MAX_OBJECTS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       job_empty,
    input  job_t       job,
    output logic       job_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_event_res,
    output logic [5:0] m_event_id,
    output logic       m_overlapping
);

    localparam int TBL_DEPTH = (MAX_OBJECTS < 64) ? MAX_OBJECTS : 64;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    logic [3:0] stp_reg;
    job_t job_reg;

    logic [TBL_DEPTH-1:0] contact_reg;

    logic signed [LANE_W-1:0] opa [4];
    logic signed [LANE_W-1:0] opb [4];
    logic signed [PROD_W-1:0] prod_reg [4];

    logic [25:0] na_reg, nb_reg, pc_reg, qc_reg;
    logic signed [59:0] dot_reg [4];
    logic [59:0] sum_reg [4];

    logic out_valid_reg;
    logic [1:0] out_res_reg;
    logic [5:0] out_id_reg;
    logic out_ovl_reg;

    logic               out_free;
    logic               last_step;
    logic               finish;
    logic               hit;
    logic               in_range;
    logic               cur_bit;
    logic [1:0]         ev;
    logic signed [PROD_W:0] pq;
    logic [PROD_W:0]    pq_abs;
    logic signed [PROD_W:0] qq;
    logic [PROD_W:0]    qq_abs;
    logic signed [LANE_W-1:0] ux_s;
    logic signed [LANE_W-1:0] uy_s;
    logic [PROD_W:0]    d2;
    logic [3:0]         sep;
    logic [60:0]        proj [4];

    assign out_free  = !out_valid_reg || m_ready;
    assign last_step = (job_reg.op == OP_CIRCLE) ? (stp_reg == 4'd1) : (stp_reg == 4'd8);
    assign finish    = (state_reg == ST_RUN) && last_step && out_free;
    assign job_pop   = (state_reg == ST_IDLE) && !job_empty;

    // circle distances
    assign ux_s = job_reg.dx[32] ? -LANE_W'(job_reg.dx) : LANE_W'(job_reg.dx);
    assign uy_s = job_reg.dy[32] ? -LANE_W'(job_reg.dy) : LANE_W'(job_reg.dy);

    // lane operand select per step
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            opa[l] = '0;
            opb[l] = '0;
        end
        if (job_reg.op == OP_CIRCLE) begin
            opa[0] = ux_s; opb[0] = ux_s;
            opa[1] = uy_s; opb[1] = uy_s;
            opa[2] = LANE_W'({1'b0, job_reg.s0} + {1'b0, job_reg.s2});
            opb[2] = opa[2];
        end else begin
            case (stp_reg)
                4'd0: begin
                    opa[0] = LANE_W'(job_reg.ca); opb[0] = LANE_W'(job_reg.ca);
                    opa[1] = LANE_W'(job_reg.sa); opb[1] = LANE_W'(job_reg.sa);
                    opa[2] = LANE_W'(job_reg.cb); opb[2] = LANE_W'(job_reg.cb);
                    opa[3] = LANE_W'(job_reg.sb); opb[3] = LANE_W'(job_reg.sb);
                end
                4'd1: begin
                    opa[0] = LANE_W'(job_reg.ca); opb[0] = LANE_W'(job_reg.cb);
                    opa[1] = LANE_W'(job_reg.sa); opb[1] = LANE_W'(job_reg.sb);
                    opa[2] = LANE_W'(job_reg.ca); opb[2] = LANE_W'(job_reg.sb);
                    opa[3] = LANE_W'(job_reg.sa); opb[3] = LANE_W'(job_reg.cb);
                end
                4'd2: begin
                    opa[0] = LANE_W'(job_reg.dx); opb[0] = LANE_W'(job_reg.ca);
                    opa[1] = LANE_W'(job_reg.dy); opb[1] = LANE_W'(job_reg.sa);
                    opa[2] = LANE_W'(job_reg.dx); opb[2] = LANE_W'(job_reg.sa);
                    opa[3] = LANE_W'(job_reg.dy); opb[3] = LANE_W'(job_reg.ca);
                end
                4'd3: begin
                    opa[0] = LANE_W'(job_reg.dx); opb[0] = LANE_W'(job_reg.cb);
                    opa[1] = LANE_W'(job_reg.dy); opb[1] = LANE_W'(job_reg.sb);
                    opa[2] = LANE_W'(job_reg.dx); opb[2] = LANE_W'(job_reg.sb);
                    opa[3] = LANE_W'(job_reg.dy); opb[3] = LANE_W'(job_reg.cb);
                end
                4'd4: begin
                    opa[0] = LANE_W'({1'b0, job_reg.s0}); opb[0] = LANE_W'({1'b0, na_reg});
                    opa[1] = LANE_W'({1'b0, job_reg.s1}); opb[1] = LANE_W'({1'b0, na_reg});
                    opa[2] = LANE_W'({1'b0, job_reg.s2}); opb[2] = LANE_W'({1'b0, nb_reg});
                    opa[3] = LANE_W'({1'b0, job_reg.s3}); opb[3] = LANE_W'({1'b0, nb_reg});
                end
                4'd5: begin
                    opa[0] = LANE_W'({1'b0, job_reg.s0}); opb[0] = LANE_W'({1'b0, pc_reg});
                    opa[1] = LANE_W'({1'b0, job_reg.s1}); opb[1] = LANE_W'({1'b0, qc_reg});
                    opa[2] = LANE_W'({1'b0, job_reg.s0}); opb[2] = LANE_W'({1'b0, qc_reg});
                    opa[3] = LANE_W'({1'b0, job_reg.s1}); opb[3] = LANE_W'({1'b0, pc_reg});
                end
                4'd6: begin
                    opa[0] = LANE_W'({1'b0, job_reg.s2}); opb[0] = LANE_W'({1'b0, pc_reg});
                    opa[1] = LANE_W'({1'b0, job_reg.s3}); opb[1] = LANE_W'({1'b0, qc_reg});
                    opa[2] = LANE_W'({1'b0, job_reg.s2}); opb[2] = LANE_W'({1'b0, qc_reg});
                    opa[3] = LANE_W'({1'b0, job_reg.s3}); opb[3] = LANE_W'({1'b0, pc_reg});
                end
                default: begin
                end
            endcase
        end
    end

    // cross terms of the axis products
    assign pq     = (PROD_W+1)'(prod_reg[0]) + (PROD_W+1)'(prod_reg[1]);
    assign pq_abs = pq[PROD_W] ? (PROD_W+1)'(-pq) : (PROD_W+1)'(pq);
    assign qq     = (PROD_W+1)'(prod_reg[2]) - (PROD_W+1)'(prod_reg[3]);
    assign qq_abs = qq[PROD_W] ? (PROD_W+1)'(-qq) : (PROD_W+1)'(qq);
    assign d2     = (PROD_W+1)'(prod_reg[0]) + (PROD_W+1)'(prod_reg[1]);

    // separating axis decision
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            proj[k] = dot_reg[k][59] ? (61'(-61'(dot_reg[k])) << 1) : (61'(dot_reg[k]) << 1);
            sep[k]  = (proj[k] >= {1'b0, sum_reg[k]});
        end
        if (job_reg.op == OP_CIRCLE) hit = ((PROD_W+1)'(prod_reg[2]) >= d2);
        else                         hit = (sep == 4'b0000);
    end

    // contact table lookup and event
    assign in_range = ({26'd0, job_reg.id} < 32'(MAX_OBJECTS));
    assign cur_bit  = in_range ? contact_reg[job_reg.id[TBL_AW-1:0]] : 1'b0;
    always_comb begin
        if (!in_range)    ev = EV_NONE;
        else if (cur_bit) ev = hit ? EV_STAY : EV_EXIT;
        else              ev = hit ? EV_ENTER : EV_NONE;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            stp_reg       <= 4'd0;
            contact_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (finish)       out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (!job_empty) begin
                        state_reg <= ST_RUN;
                        stp_reg   <= 4'd0;
                    end
                end
                ST_RUN: begin
                    if (finish) begin
                        state_reg <= ST_IDLE;
                        if (in_range)
                            contact_reg[job_reg.id[TBL_AW-1:0]] <= hit;
                    end else if (!last_step) begin
                        stp_reg <= stp_reg + 4'd1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (job_pop) job_reg <= job;
        for (int l = 0; l < 4; l++) prod_reg[l] <= opa[l] * opb[l];
        if (state_reg == ST_RUN && job_reg.op == OP_BOX) begin
            case (stp_reg)
                4'd1: begin
                    na_reg <= d2[49:24];
                    nb_reg <= 26'(((PROD_W+1)'(prod_reg[2]) + (PROD_W+1)'(prod_reg[3])) >> 24);
                end
                4'd2: begin
                    pc_reg <= pq_abs[49:24];
                    qc_reg <= qq_abs[49:24];
                end
                4'd3: begin
                    dot_reg[0] <= pq[59:0];
                    dot_reg[1] <= qq[59:0];
                end
                4'd4: begin
                    dot_reg[2] <= pq[59:0];
                    dot_reg[3] <= qq[59:0];
                end
                4'd5: begin
                    for (int l = 0; l < 4; l++) sum_reg[l] <= prod_reg[l][59:0];
                end
                4'd6: begin
                    sum_reg[2] <= sum_reg[2] + prod_reg[0][59:0] + prod_reg[1][59:0];
                    sum_reg[3] <= sum_reg[3] + prod_reg[2][59:0] + prod_reg[3][59:0];
                end
                4'd7: begin
                    sum_reg[0] <= sum_reg[0] + prod_reg[0][59:0] + prod_reg[1][59:0];
                    sum_reg[1] <= sum_reg[1] + prod_reg[2][59:0] + prod_reg[3][59:0];
                end
                default: begin
                end
            endcase
        end
        if (finish) begin
            out_res_reg <= ev;
            out_id_reg  <= job_reg.id;
            out_ovl_reg <= hit;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_event_res   = out_res_reg;
    assign m_event_id    = out_id_reg;
    assign m_overlapping = out_ovl_reg;

endmodule
